// ----- hdl/melody_tone_sequencer_assert.svh -----
// Assertion macros used by the melody tone sequencer RTL.
`ifndef MELODY_TONE_SEQUENCER_ASSERT_SVH
`define MELODY_TONE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("melody_tone_sequencer: same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("melody_tone_sequencer: next-cycle check failed");

`endif

// ----- hdl/mts_pkg.sv -----
// Types, codes and constants of the melody tone sequencer.
`default_nettype none

package mts_pkg;

	localparam int MAX_NOTES_DEF = 64;
	localparam int MLEN_W        = 7;
	localparam int IDX_W         = 6;
	localparam int FREQ_W        = 16;
	localparam int DUR_W         = 16;
	localparam int ENTRY_W       = FREQ_W + DUR_W;
	localparam int MICRO_W       = 10;
	localparam int HALF_W        = 19;
	localparam int DIVISOR_W     = FREQ_W + 1;
	localparam int DIV_STEPS     = HALF_W;

	localparam logic [MICRO_W-1:0] US_PER_MS     = MICRO_W'(1000);
	// (1000000 / f) / 2 == 500000 / f
	localparam logic [HALF_W-1:0]  HALF_DIVIDEND = HALF_W'(1000000 / 2);

	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_WRITE  = 3'd1,
		REQ_PLAY   = 3'd2,
		REQ_STOP   = 3'd3,
		REQ_TOGGLE = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_PLAYING = 2'd1,
		MODE_PAUSED  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [HALF_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/mts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mts_div.sv -----
// Restoring divider for the tone half period, one quotient bit per cycle.
`default_nettype none

module mts_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mts_pkg::div_req_t req,
	output mts_pkg::div_rsp_t     rsp
);

	localparam int CNT_W = $clog2(mts_pkg::DIV_STEPS + 1);

	logic                            busy_q;
	logic                            done_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [mts_pkg::DIVISOR_W-1:0]   dvs_q;
	logic [mts_pkg::DIVISOR_W-1:0]   rem_q;
	logic [mts_pkg::HALF_W-1:0]      quo_q;
	logic [mts_pkg::DIVISOR_W:0]     trial;
	logic                            fits;

	// quo_q shifts dividend bits out at the top and quotient bits in at the bottom
	assign trial = {rem_q, quo_q[mts_pkg::HALF_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(mts_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= mts_pkg::HALF_DIVIDEND;
		end else if (busy_q) begin
			rem_q <= fits ? mts_pkg::DIVISOR_W'(trial - {1'b0, dvs_q})
			              : trial[mts_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[mts_pkg::HALF_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// ----- hdl/melody_tone_sequencer.sv -----
// Items that start no note pass from acceptance through the FIN state to the result register.
// A note start (play, or a tick that ends a note) reads the note store, then for a tone
// runs the 19-step half-period divider; a rest goes from LOAD straight to FIN.
// One item is in flight at a time; the next is taken the cycle after its result is registered.
// Reset: stopped, position 0, counters and level clear, melody_length 0; note store undefined.
`default_nettype none
`include "melody_tone_sequencer_assert.svh"

module melody_tone_sequencer #(
	parameter int MAX_NOTES = mts_pkg::MAX_NOTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [mts_pkg::MLEN_W-1:0]  cfg_wdata,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic [2:0]                  req_type,
	input  wire logic [mts_pkg::IDX_W-1:0]   note_index,
	input  wire logic [mts_pkg::FREQ_W-1:0]  note_freq_hz,
	input  wire logic [mts_pkg::DUR_W-1:0]   note_duration_ms,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic                             buzzer_level,
	output logic [1:0]                       play_state,
	output logic [mts_pkg::IDX_W-1:0]        note_position,
	output logic                             note_begun
);

	localparam int PW = $clog2(MAX_NOTES);
	localparam int NW = ((PW > mts_pkg::MLEN_W) ? PW : mts_pkg::MLEN_W) + 1;
	localparam logic [NW-1:0] MAXN = NW'(MAX_NOTES);

	mts_pkg::state_t state_q, state_d;
	mts_pkg::mode_t  mode_q, mode_d;

	logic [mts_pkg::MLEN_W-1:0]  mlen_q;
	logic [PW-1:0]               position_q, position_d;
	logic [mts_pkg::MICRO_W-1:0] micro_q, micro_d;
	logic [mts_pkg::DUR_W-1:0]   milli_q, milli_d;
	logic [mts_pkg::DUR_W-1:0]   note_len_q, note_len_d;
	logic [mts_pkg::HALF_W-1:0]  half_p_q, half_p_d;
	logic [mts_pkg::HALF_W-1:0]  half_c_q, half_c_d;
	logic                        level_q, level_d;
	logic                        begun_q, begun_d;
	logic                        rsp_valid_q, rsp_valid_d;
	logic                        out_load;

	logic                        accept;
	logic [NW-1:0]               act_len;
	logic [NW-1:0]               next_pos;
	logic [mts_pkg::HALF_W:0]    hc_inc;
	logic [mts_pkg::MICRO_W:0]   mc_inc;

	logic                        ram_we;
	logic                        ram_re;
	logic [PW-1:0]               ram_raddr;
	logic [mts_pkg::ENTRY_W-1:0] ram_rdata;

	mts_pkg::div_req_t div_req;
	mts_pkg::div_rsp_t div_rsp;

	mts_ram #(
		.WIDTH(mts_pkg::ENTRY_W),
		.DEPTH(MAX_NOTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(PW'(note_index)),
		.wdata({note_freq_hz, note_duration_ms}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mts_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign req_stall = state_q != mts_pkg::ST_IDLE;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		act_len  = (NW'(mlen_q) > MAXN) ? MAXN : NW'(mlen_q);
		next_pos = NW'(position_q) + NW'(1);
		if (next_pos >= act_len) begin
			next_pos = '0;
		end
		hc_inc = {1'b0, half_c_q} + (mts_pkg::HALF_W + 1)'(1);
		mc_inc = {1'b0, micro_q} + (mts_pkg::MICRO_W + 1)'(1);
	end

	always_comb begin
		state_d       = state_q;
		mode_d        = mode_q;
		position_d    = position_q;
		micro_d       = micro_q;
		milli_d       = milli_q;
		note_len_d    = note_len_q;
		half_p_d      = half_p_q;
		half_c_d      = half_c_q;
		level_d       = level_q;
		begun_d       = begun_q;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = '0;
		div_req       = '0;
		div_req.divisor = {1'b0, ram_rdata[mts_pkg::ENTRY_W-1:mts_pkg::DUR_W]};
		out_load      = 1'b0;

		unique case (state_q)
			mts_pkg::ST_IDLE: begin
				if (accept) begin
					begun_d = 1'b0;
					state_d = mts_pkg::ST_FIN;
					unique case (mts_pkg::req_t'(req_type))
						mts_pkg::REQ_TICK: begin
							if (mode_q == mts_pkg::MODE_PLAYING) begin
								if (half_p_q != '0) begin
									if (hc_inc >= {1'b0, half_p_q}) begin
										half_c_d = '0;
										level_d  = ~level_q;
									end else begin
										half_c_d = hc_inc[mts_pkg::HALF_W-1:0];
									end
								end
								micro_d = mc_inc[mts_pkg::MICRO_W-1:0];
								milli_d = milli_q;
								if (mc_inc >= {1'b0, mts_pkg::US_PER_MS}) begin
									micro_d = '0;
									milli_d = milli_q + mts_pkg::DUR_W'(1);
								end
								if (milli_d >= note_len_q) begin
									position_d = PW'(next_pos);
									ram_re     = 1'b1;
									ram_raddr  = PW'(next_pos);
									begun_d    = 1'b1;
									state_d    = mts_pkg::ST_LOAD;
								end
							end
						end
						mts_pkg::REQ_WRITE: begin
							ram_we = NW'(note_index) < MAXN;
						end
						mts_pkg::REQ_PLAY: begin
							if (act_len != '0) begin
								mode_d     = mts_pkg::MODE_PLAYING;
								position_d = '0;
								ram_re     = 1'b1;
								begun_d    = 1'b1;
								state_d    = mts_pkg::ST_LOAD;
							end
						end
						mts_pkg::REQ_STOP: begin
							mode_d     = mts_pkg::MODE_STOPPED;
							position_d = '0;
							micro_d    = '0;
							milli_d    = '0;
							half_c_d   = '0;
							level_d    = 1'b0;
						end
						mts_pkg::REQ_TOGGLE: begin
							if (mode_q == mts_pkg::MODE_PLAYING) begin
								mode_d  = mts_pkg::MODE_PAUSED;
								level_d = 1'b0;
							end else if (mode_q == mts_pkg::MODE_PAUSED) begin
								mode_d   = mts_pkg::MODE_PLAYING;
								micro_d  = '0;
								milli_d  = '0;
								half_c_d = '0;
								level_d  = half_p_q != '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			mts_pkg::ST_LOAD: begin
				note_len_d = ram_rdata[mts_pkg::DUR_W-1:0];
				micro_d    = '0;
				milli_d    = '0;
				half_c_d   = '0;
				if (ram_rdata[mts_pkg::ENTRY_W-1:mts_pkg::DUR_W] == '0) begin
					// rest: no tone, buzzer held low
					half_p_d = '0;
					level_d  = 1'b0;
					state_d  = mts_pkg::ST_FIN;
				end else begin
					div_req.start = 1'b1;
					state_d       = mts_pkg::ST_DIV;
				end
			end
			mts_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					half_p_d = div_rsp.quotient;
					level_d  = div_rsp.quotient != '0;
					state_d  = mts_pkg::ST_FIN;
				end
			end
			mts_pkg::ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = mts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mts_pkg::ST_IDLE;
			end
		endcase

		rsp_valid_d = out_load ? 1'b1 : (rsp_valid_q && rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mts_pkg::ST_IDLE;
			mode_q      <= mts_pkg::MODE_STOPPED;
			mlen_q      <= '0;
			position_q  <= '0;
			micro_q     <= '0;
			milli_q     <= '0;
			note_len_q  <= '0;
			half_p_q    <= '0;
			half_c_q    <= '0;
			level_q     <= 1'b0;
			begun_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			mode_q      <= mode_d;
			position_q  <= position_d;
			micro_q     <= micro_d;
			milli_q     <= milli_d;
			note_len_q  <= note_len_d;
			half_p_q    <= half_p_d;
			half_c_q    <= half_c_d;
			level_q     <= level_d;
			begun_q     <= begun_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_we) begin
				mlen_q <= cfg_wdata;
			end
		end
	end

	// result item register
	always_ff @(posedge clk) begin
		if (out_load) begin
			buzzer_level  <= level_q;
			play_state    <= mode_q;
			note_position <= mts_pkg::IDX_W'(position_q);
			note_begun    <= begun_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

	`MTS_ASSERT_NOW(a_pause_quiet, mode_q == mts_pkg::MODE_PAUSED, !level_q)
	`MTS_ASSERT_NOW(a_stop_home, mode_q == mts_pkg::MODE_STOPPED, position_q == '0 && !level_q)
	`MTS_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_q == mts_pkg::ST_DIV)
	`MTS_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_q != mts_pkg::ST_IDLE)

endmodule

`default_nettype wire

// ----- verif/melody_tone_sequencer_checker.sv -----
// Checker for the melody tone sequencer: follows the player state and compares every result item.
module melody_tone_sequencer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mts_pkg::MLEN_W-1:0]    cfg_wdata,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic [2:0]                    req_type,
	input  logic [mts_pkg::IDX_W-1:0]     note_index,
	input  logic [mts_pkg::FREQ_W-1:0]    note_freq_hz,
	input  logic [mts_pkg::DUR_W-1:0]     note_duration_ms,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  logic                          buzzer_level,
	input  logic [1:0]                    play_state,
	input  logic [mts_pkg::IDX_W-1:0]     note_position,
	input  logic                          note_begun,
	output int                            pending_results,
	output int                            fail_count
);

	localparam int STORE_DEPTH  = mts_pkg::MAX_NOTES_DEF;
	localparam int US_PER_S     = 1000000;
	localparam int US_PER_MS    = 1000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic                      level;
		logic [1:0]                state;
		logic [mts_pkg::IDX_W-1:0] position;
		logic                      begun;
	} player_view_t;

	logic [mts_pkg::ENTRY_W-1:0]  note_mem [STORE_DEPTH];
	logic [mts_pkg::MLEN_W-1:0]   tune_len;
	mts_pkg::mode_t               player_mode;
	logic [mts_pkg::IDX_W-1:0]    cur_note;
	logic [mts_pkg::MICRO_W-1:0]  us_count;
	logic [mts_pkg::DUR_W-1:0]    ms_count;
	logic [mts_pkg::DUR_W-1:0]    held_len;
	logic [mts_pkg::HALF_W-1:0]   half_len;
	logic [mts_pkg::HALF_W-1:0]   half_elapsed;
	logic                         pin;
	player_view_t                 due_outputs [$];
	player_view_t                 got;
	player_view_t                 want;
	int                           mismatches;

	assign fail_count = mismatches;

	function automatic int tune_notes();
		return (tune_len > STORE_DEPTH) ? STORE_DEPTH : int'(tune_len);
	endfunction

	function automatic void restart_note_timers();
		us_count = '0;
		ms_count = '0;
		half_elapsed = '0;
		pin = (half_len != '0);
	endfunction

	function automatic void start_note(int idx);
		logic [mts_pkg::FREQ_W-1:0] freq;
		cur_note = mts_pkg::IDX_W'(idx);
		{freq, held_len} = note_mem[idx];
		half_len = (freq != '0) ? mts_pkg::HALF_W'((US_PER_S / int'(freq)) / 2) : '0;
		restart_note_timers();
	endfunction

	function automatic player_view_t apply_request(logic [2:0] kind, logic [mts_pkg::IDX_W-1:0] idx,
			logic [mts_pkg::FREQ_W-1:0] freq, logic [mts_pkg::DUR_W-1:0] dur);
		player_view_t view;
		logic begun;
		int next;
		begun = 1'b0;
		case (kind)
		mts_pkg::REQ_TICK: begin
			if (player_mode == mts_pkg::MODE_PLAYING) begin
				if (half_len != '0) begin
					half_elapsed = half_elapsed + 1'b1;
					if (half_elapsed >= half_len) begin
						half_elapsed = '0;
						pin = ~pin;
					end
				end
				us_count = us_count + 1'b1;
				if (us_count >= mts_pkg::MICRO_W'(US_PER_MS)) begin
					us_count = '0;
					ms_count = ms_count + 1'b1;
				end
				// a zero-length note is left on its first tick
				if (ms_count >= held_len) begin
					next = int'(cur_note) + 1;
					if (next >= tune_notes())
						next = 0;
					start_note(next);
					begun = 1'b1;
				end
			end
		end
		mts_pkg::REQ_WRITE: begin
			note_mem[idx] = {freq, dur};
		end
		mts_pkg::REQ_PLAY: begin
			if (tune_notes() != 0) begin
				start_note(0);
				player_mode = mts_pkg::MODE_PLAYING;
				begun = 1'b1;
			end
		end
		mts_pkg::REQ_STOP: begin
			player_mode = mts_pkg::MODE_STOPPED;
			cur_note = '0;
			us_count = '0;
			ms_count = '0;
			half_elapsed = '0;
			pin = 1'b0;
		end
		mts_pkg::REQ_TOGGLE: begin
			if (player_mode == mts_pkg::MODE_PLAYING) begin
				player_mode = mts_pkg::MODE_PAUSED;
				pin = 1'b0;
			end else if (player_mode == mts_pkg::MODE_PAUSED) begin
				player_mode = mts_pkg::MODE_PLAYING;
				restart_note_timers();
			end
		end
		default: begin
		end
		endcase
		view.level = pin;
		view.state = player_mode;
		view.position = cur_note;
		view.begun = begun;
		return view;
	endfunction

	task automatic flag_result(input bit orphan, input player_view_t exp_v, input player_view_t act_v);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			if (orphan)
				$display("%0t: result item with nothing outstanding: level %0b state %0d pos %0d begun %0b",
					$time, act_v.level, act_v.state, act_v.position, act_v.begun);
			else
				$display("%0t: mismatch, expected level %0b state %0d pos %0d begun %0b, got %0b %0d %0d %0b",
					$time, exp_v.level, exp_v.state, exp_v.position, exp_v.begun,
					act_v.level, act_v.state, act_v.position, act_v.begun);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tune_len = '0;
			player_mode = mts_pkg::MODE_STOPPED;
			cur_note = '0;
			us_count = '0;
			ms_count = '0;
			held_len = '0;
			half_len = '0;
			half_elapsed = '0;
			pin = 1'b0;
			due_outputs.delete();
			mismatches = 0;
			pending_results <= 0;
		end else begin
			if (cfg_we)
				tune_len = cfg_wdata;
			if (rsp_valid && !rsp_stall) begin
				got = {buzzer_level, play_state, note_position, note_begun};
				if (due_outputs.size() == 0) begin
					flag_result(1'b1, got, got);
				end else begin
					want = due_outputs.pop_front();
					if (got !== want)
						flag_result(1'b0, want, got);
				end
			end
			if (req_valid && !req_stall)
				due_outputs.push_back(apply_request(req_type, note_index, note_freq_hz, note_duration_ms));
			pending_results <= due_outputs.size();
		end
	end

endmodule

// ----- verif/melody_tone_sequencer_tb.sv -----
// Testbench top for the melody tone sequencer: drives request items, the length register and back-pressure.
module melody_tone_sequencer_tb;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 5;
	localparam int MAX_GAP      = 18;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1800;
	localparam int NOTE_SLOTS   = mts_pkg::MAX_NOTES_DEF;

	localparam logic [2:0] REQ_RSVD_LO = 3'd5;
	localparam logic [2:0] REQ_RSVD_HI = 3'd7;

	localparam logic [mts_pkg::MLEN_W-1:0] LEN_NONE     = '0;
	localparam logic [mts_pkg::MLEN_W-1:0] LEN_FULL     = mts_pkg::MLEN_W'(NOTE_SLOTS);
	localparam logic [mts_pkg::MLEN_W-1:0] LEN_ALL_ONES = '1;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [mts_pkg::MLEN_W-1:0]    cfg_wdata;
	logic                          req_valid;
	logic                          req_stall;
	logic [2:0]                    req_type;
	logic [mts_pkg::IDX_W-1:0]     note_index;
	logic [mts_pkg::FREQ_W-1:0]    note_freq_hz;
	logic [mts_pkg::DUR_W-1:0]     note_duration_ms;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic                          buzzer_level;
	logic [1:0]                    play_state;
	logic [mts_pkg::IDX_W-1:0]     note_position;
	logic                          note_begun;
	int                            pending_results;
	int                            fail_count;

	bit quiet;          // no idling on either side
	bit hold_request;   // receiver holds off for a long stretch
	int random_done;
	int cycle_count;

	melody_tone_sequencer u_dut (.*);

	melody_tone_sequencer_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : rsp_side
		int stall_cycles;
		rsp_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				stall_cycles = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				stall_cycles = quiet ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall_cycles != 0) begin
				rsp_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
		end
	end

	// valid stays high across back-to-back items; it is lowered only before a gap or by settle_player
	task automatic send_item(input logic [2:0] kind, input logic [mts_pkg::IDX_W-1:0] idx,
			input logic [mts_pkg::FREQ_W-1:0] freq, input logic [mts_pkg::DUR_W-1:0] dur);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		note_index <= idx;
		note_freq_hz <= freq;
		note_duration_ms <= dur;
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	task automatic settle_player();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	task automatic set_tune_len(input logic [mts_pkg::MLEN_W-1:0] len);
		settle_player();
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly rests and top-of-range tones so the toggling shows within a short note
	function automatic logic [mts_pkg::FREQ_W-1:0] pick_freq();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return '0;
		else if (r < 6)
			return 16'($urandom_range(62500, 65535));
		return 16'($urandom);
	endfunction

	// short notes keep the melody moving; a 1 ms note takes a thousand ticks
	function automatic logic [mts_pkg::DUR_W-1:0] pick_dur();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return '0;
		else if (r < 90)
			return 16'd1;
		else if (r < 98)
			return 16'($urandom_range(2, 3));
		return 16'($urandom);
	endfunction

	task automatic random_item(input bit noisy);
		logic [2:0] kind;
		int r;
		r = $urandom_range(0, 99);
		if (noisy)
			kind = 3'($urandom_range(0, 7));
		else if (r < 80)
			kind = mts_pkg::REQ_TICK;
		else if (r < 85)
			kind = mts_pkg::REQ_TOGGLE;
		else if (r < 90)
			kind = mts_pkg::REQ_WRITE;
		else if (r < 94)
			kind = mts_pkg::REQ_PLAY;
		else if (r < 96)
			kind = mts_pkg::REQ_STOP;
		else
			kind = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
		if (kind == mts_pkg::REQ_WRITE)
			send_item(kind, 6'($urandom), pick_freq(), pick_dur());
		else
			send_item(kind, 6'($urandom), 16'($urandom), 16'($urandom));
		if (kind < REQ_RSVD_LO)
			random_done++;
	endtask

	initial begin : stimulus
		int phase;
		int span;
		int r;
		bit noisy;
		logic [mts_pkg::MLEN_W-1:0] len;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_valid <= 1'b0;
		req_type <= mts_pkg::REQ_TICK;
		note_index <= '0;
		note_freq_hz <= '0;
		note_duration_ms <= '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		random_done = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// empty melody: play does nothing, stopped-mode items leave the player state unchanged
		set_tune_len(LEN_NONE);
		send_item(mts_pkg::REQ_TICK, '0, '0, '0);
		send_item(mts_pkg::REQ_PLAY, '0, '0, '0);
		send_item(mts_pkg::REQ_TOGGLE, '0, '0, '0);
		send_item(mts_pkg::REQ_STOP, '1, '1, '1);
		send_item(REQ_RSVD_LO, '0, '0, '0);
		send_item(REQ_RSVD_HI, '1, '1, '1);
		send_item(mts_pkg::REQ_WRITE, 6'd0, 16'd0, 16'd0);
		send_item(mts_pkg::REQ_WRITE, 6'd1, 16'hFFFF, 16'd1);
		send_item(mts_pkg::REQ_WRITE, 6'd2, 16'd1, 16'd0);
		send_item(mts_pkg::REQ_WRITE, 6'd63, 16'hFFFF, 16'hFFFF);

		// three notes: zero-length rest, fast tone, slowest tone
		set_tune_len(7'd3);
		send_item(mts_pkg::REQ_PLAY, '0, '0, '0);
		send_item(mts_pkg::REQ_TICK, '0, '0, '0);
		send_item(mts_pkg::REQ_TICK, '1, '1, '1);
		send_item(mts_pkg::REQ_TICK, '0, '0, '0);
		send_item(mts_pkg::REQ_TOGGLE, '0, '0, '0);
		send_item(mts_pkg::REQ_TICK, '0, '0, '0);
		send_item(mts_pkg::REQ_WRITE, 6'd2, 16'd2, 16'd0);
		send_item(mts_pkg::REQ_TOGGLE, '0, '0, '0);
		send_item(mts_pkg::REQ_TICK, '0, '0, '0);
		send_item(mts_pkg::REQ_PLAY, '0, '0, '0);
		send_item(mts_pkg::REQ_TOGGLE, '0, '0, '0);
		send_item(mts_pkg::REQ_PLAY, '0, '0, '0);
		send_item(mts_pkg::REQ_STOP, '0, '0, '0);
		send_item(mts_pkg::REQ_TICK, '0, '0, '0);

		// every store entry gets written before any length can reach it
		for (int slot = 0; slot < NOTE_SLOTS; slot++)
			send_item(mts_pkg::REQ_WRITE, 6'(slot), pick_freq(), pick_dur());

		phase = 0;
		while (random_done < RANDOM_ITEMS) begin
			case (phase)
			0: len = LEN_FULL;
			1: len = LEN_ALL_ONES;
			2: len = LEN_NONE;
			3: len = 7'd1;
			default: begin
				r = $urandom_range(0, 3);
				if (r < 2)
					len = 7'($urandom_range(1, 8));
				else if (r == 2)
					len = 7'($urandom_range(1, NOTE_SLOTS));
				else
					len = 7'd2;
			end
			endcase
			quiet = (phase % 5 == 3);
			set_tune_len(len);
			if (phase == 1) begin
				quiet = 1'b1;
				hold_request = 1'b1;
			end
			noisy = (phase % 7 == 6);
			span = $urandom_range(30, 150);
			if (!noisy)
				send_item(mts_pkg::REQ_PLAY, 6'($urandom), 16'($urandom), 16'($urandom));
			repeat (span) random_item(noisy);
			phase++;
		end

		settle_player();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
